@@ hdl/texel_color_combiner_assert.svh @@
// Assertion macros used by the checker file of the texel color combiner.
// Each macro expands to one labeled concurrent assertion on the rising clock,
// disabled while the active-low reset is asserted.
`ifndef TEXEL_COLOR_COMBINER_ASSERT_SVH
`define TEXEL_COLOR_COMBINER_ASSERT_SVH

// The consequent must hold at the same edge as the antecedent.
`define TCC_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("texel color combiner: same-cycle check failed");

// The consequent must hold a fixed number of edges after the antecedent.
`define TCC_ASSERT_LATER(lbl, clk_s, rstn_s, ante, n, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> ##(n) (cons)) \
    else $error("texel color combiner: delayed check failed");

`endif

@@ hdl/tcc_pkg.sv @@
// ----------------------------------------------------------------------------
// tcc_pkg
// Types and fixed constants of the texel color combiner: register indexes,
// reset values, divisor constants and the per-channel configuration bundle.
// ----------------------------------------------------------------------------
package tcc_pkg;

  // Pipeline depth from input beat to result strobe.
  localparam int NUM_STAGES = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_ZERO  = 3'd0,
    CFG_COLOR_ONE   = 3'd1,
    CFG_KONST_COLOR = 3'd2,
    CFG_TINT_COLOR  = 3'd3,
    CFG_KONST_ALPHA = 3'd4,
    CFG_RING_MODE   = 3'd5,
    CFG_MASK_COLOR  = 3'd6
  } cfg_idx_t;

  localparam logic [23:0] TINT_RESET        = 24'hFF_FFFF;
  localparam logic [7:0]  KONST_ALPHA_RESET = 8'hFF;

  // Normal path divides by 255^3, alpha path by 255^2.
  localparam logic [23:0] NORM_DIV  = 24'd16581375;
  localparam logic [31:0] NORM_HALF = 32'd8290687;
  localparam logic [16:0] ALPHA_DIV  = 17'd65025;
  localparam logic [21:0] ALPHA_HALF = 22'd32512;

  // Configuration seen by one color channel.
  typedef struct packed {
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] k0;
    logic [7:0] tint;
    logic       ring;
  } chan_cfg_t;

  // round(q * 255 / 63) for a six-bit q: 4q plus round(q / 21).
  function automatic logic [7:0] expand6to8(input logic [5:0] q);
    logic [1:0] frac;
    begin
      if (q >= 6'd53) begin
        frac = 2'd3;
      end else if (q >= 6'd32) begin
        frac = 2'd2;
      end else if (q >= 6'd11) begin
        frac = 2'd1;
      end else begin
        frac = 2'd0;
      end
      expand6to8 = {q, 2'b00} + {6'd0, frac};
    end
  endfunction

endpackage

@@ hdl/texel_color_combiner.sv @@
// ----------------------------------------------------------------------------
// texel_color_combiner
// RGBA8 texture combiner, ring and normal modes, a texel a clock unless busy.
// ----------------------------------------------------------------------------
// Usage: a texel beat is taken at each rising edge where start is high and
// busy is low. busy is only high during reset and for the first cycle after
// it; otherwise the block takes a new texel in every cycle, so throughput is
// one texel per clock.
// The combined texel appears on the out_ ports for exactly one cycle, marked
// by out_valid, once its beat has passed through every pipeline stage. The depth
// is set by the normal-mode divide by 255^3, which needs two quotient
// estimates and a final compare after the wide product. The receiver cannot
// stall, so the pipeline never holds.
// Configuration writes use cfg_valid/cfg_ready with a register index and data;
// cfg_ready is always high. Index 7 is ignored. Registers should only be
// written while no texel is in flight.
// Reset (synchronous, active low) empties the pipeline and restores the
// register defaults: all colors zero, tint white, alpha scale 1.0, normal mode.
// ----------------------------------------------------------------------------
module texel_color_combiner (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [7:0]                       in_red_in,
  input  logic [7:0]                       in_green_in,
  input  logic [7:0]                       in_blue_in,
  input  logic [7:0]                       in_alpha_in,
  output logic                             out_valid,
  output logic [7:0]                       out_red_out,
  output logic [7:0]                       out_green_out,
  output logic [7:0]                       out_blue_out,
  output logic [7:0]                       out_alpha_out,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tcc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tcc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  // --------------------------------------------------------------------------
  // Handshakes. The block never pushes back once out of reset, so busy is a
  // register that drops in the cycle after reset releases.
  // --------------------------------------------------------------------------
  logic busy_r;
  logic in_accept;
  logic cfg_write;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign in_accept = start && !busy_r;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [23:0] color_zero_r, color_zero_nxt;
  logic [23:0] color_one_r, color_one_nxt;
  logic [23:0] konst_color_r, konst_color_nxt;
  logic [23:0] tint_color_r, tint_color_nxt;
  logic [7:0]  konst_alpha_r, konst_alpha_nxt;
  logic        ring_mode_r, ring_mode_nxt;
  logic        mask_color_r, mask_color_nxt;

  always_comb begin
    color_zero_nxt  = color_zero_r;
    color_one_nxt   = color_one_r;
    konst_color_nxt = konst_color_r;
    tint_color_nxt  = tint_color_r;
    konst_alpha_nxt = konst_alpha_r;
    ring_mode_nxt   = ring_mode_r;
    mask_color_nxt  = mask_color_r;
    if (cfg_write) begin
      case (tcc_pkg::cfg_idx_t'(cfg_index))
        tcc_pkg::CFG_COLOR_ZERO:  color_zero_nxt  = cfg_data;
        tcc_pkg::CFG_COLOR_ONE:   color_one_nxt   = cfg_data;
        tcc_pkg::CFG_KONST_COLOR: konst_color_nxt = cfg_data;
        tcc_pkg::CFG_TINT_COLOR:  tint_color_nxt  = cfg_data;
        tcc_pkg::CFG_KONST_ALPHA: konst_alpha_nxt = cfg_data[7:0];
        tcc_pkg::CFG_RING_MODE:   ring_mode_nxt   = cfg_data[0];
        tcc_pkg::CFG_MASK_COLOR:  mask_color_nxt  = cfg_data[0];
        default: begin
          // Writes past the register list are dropped.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_zero_r  <= '0;
      color_one_r   <= '0;
      konst_color_r <= '0;
      tint_color_r  <= tcc_pkg::TINT_RESET;
      konst_alpha_r <= tcc_pkg::KONST_ALPHA_RESET;
      ring_mode_r   <= 1'b0;
      mask_color_r  <= 1'b0;
    end else begin
      color_zero_r  <= color_zero_nxt;
      color_one_r   <= color_one_nxt;
      konst_color_r <= konst_color_nxt;
      tint_color_r  <= tint_color_nxt;
      konst_alpha_r <= konst_alpha_nxt;
      ring_mode_r   <= ring_mode_nxt;
      mask_color_r  <= mask_color_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Valid bits. Each stage's bit moves one step per clock alongside its data;
  // the last one is the result strobe.
  // --------------------------------------------------------------------------
  logic [tcc_pkg::NUM_STAGES-1:0] stg_vld_r, stg_vld_nxt;

  assign stg_vld_nxt = {stg_vld_r[tcc_pkg::NUM_STAGES-2:0], in_accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= '0;
    end else begin
      stg_vld_r <= stg_vld_nxt;
    end
  end

  assign out_valid = stg_vld_r[tcc_pkg::NUM_STAGES-1];

  // --------------------------------------------------------------------------
  // Color channels. Red sits in the top byte of each packed color, blue in
  // the bottom byte. In normal mode with the mask set, texel alpha is the
  // lerp factor of every channel.
  // --------------------------------------------------------------------------
  logic [7:0] tex_in [3];
  logic [7:0] chan_res [3];

  assign tex_in[0] = in_red_in;
  assign tex_in[1] = in_green_in;
  assign tex_in[2] = in_blue_in;

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    localparam int LSB = 16 - 8 * ch;
    tcc_pkg::chan_cfg_t chan_cfg;
    logic [7:0]         chan_fac;

    assign chan_cfg.c0   = color_zero_r[LSB +: 8];
    assign chan_cfg.c1   = color_one_r[LSB +: 8];
    assign chan_cfg.k0   = konst_color_r[LSB +: 8];
    assign chan_cfg.tint = tint_color_r[LSB +: 8];
    assign chan_cfg.ring = ring_mode_r;
    assign chan_fac      = mask_color_r ? in_alpha_in : tex_in[ch];

    tcc_chan u_chan (
      .clk (clk),
      .cfg (chan_cfg),
      .tex (tex_in[ch]),
      .fac (chan_fac),
      .res (chan_res[ch])
    );
  end

  assign out_red_out   = chan_res[0];
  assign out_green_out = chan_res[1];
  assign out_blue_out  = chan_res[2];

  // --------------------------------------------------------------------------
  // Alpha. Ring mode scales by konst_alpha and rounds to six bits:
  // q = floor((a*k*63 + 32512) / 65025). Since 65025 is just below 2^16, the
  // top bits give an estimate that is short by at most one, fixed by a single
  // compare. The six-bit value is then expanded back to eight bits. Normal
  // mode passes texel alpha through, delayed to match the color channels.
  // --------------------------------------------------------------------------
  logic [15:0] a_s1_p_r, a_s1_p_nxt;
  logic [21:0] a_s2_n_r, a_s2_n_nxt;
  logic [21:0] a_s3_n_r;
  logic [5:0]  a_s4_q_r, a_s4_q_nxt;
  logic [7:0]  a_s5_res_r, a_s5_res_nxt;
  logic [7:0]  a_pass_r [tcc_pkg::NUM_STAGES-1];
  logic [5:0]  a_q0;
  logic [21:0] a_rem;
  logic [6:0]  a_qsum;

  always_comb begin
    a_s1_p_nxt   = 16'(in_alpha_in) * 16'(konst_alpha_r);
    a_s2_n_nxt   = 22'(a_s1_p_r) * 22'd63 + tcc_pkg::ALPHA_HALF;
    a_q0         = a_s3_n_r[21:16];
    a_rem        = a_s3_n_r - 22'(a_q0) * 22'(tcc_pkg::ALPHA_DIV);
    a_qsum       = {1'b0, a_q0} + {6'd0, (a_rem >= 22'(tcc_pkg::ALPHA_DIV))};
    a_s4_q_nxt   = a_qsum[5:0];
    a_s5_res_nxt = ring_mode_r ? tcc_pkg::expand6to8(a_s4_q_r)
                               : a_pass_r[tcc_pkg::NUM_STAGES-2];
  end

  always_ff @(posedge clk) begin
    a_s1_p_r   <= a_s1_p_nxt;
    a_s2_n_r   <= a_s2_n_nxt;
    a_s3_n_r   <= a_s2_n_r;
    a_s4_q_r   <= a_s4_q_nxt;
    a_s5_res_r <= a_s5_res_nxt;
    a_pass_r[0] <= in_alpha_in;
    for (int i = 1; i < tcc_pkg::NUM_STAGES - 1; i++) begin
      a_pass_r[i] <= a_pass_r[i-1];
    end
  end

  assign out_alpha_out = a_s5_res_r;

endmodule

@@ hdl/tcc_chan.sv @@
// ----------------------------------------------------------------------------
// tcc_chan
// Five-stage datapath for one color channel: ring lerp and tint, and the
// normal-mode product with its rounded division by 255^3.
// ----------------------------------------------------------------------------
module tcc_chan (
  input  logic                clk,
  input  tcc_pkg::chan_cfg_t  cfg,
  input  logic [7:0]          tex,
  input  logic [7:0]          fac,
  output logic [7:0]          res
);

  // Stage 1: lerps and the constant product.
  logic [8:0]  w;
  logic [16:0] ring_sum;
  logic [16:0] mix_sum;
  logic [7:0]  s1_m_r, s1_m_nxt;
  logic [15:0] s1_mix_r, s1_mix_nxt;
  logic [15:0] s1_ptc_r, s1_ptc_nxt;

  always_comb begin
    w          = {1'b0, tex} + {8'd0, tex[7]};
    ring_sum   = 17'(cfg.c1) * 17'(9'd256 - w) + 17'(cfg.c0) * 17'(w) + 17'd128;
    s1_m_nxt   = ring_sum[15:8];
    mix_sum    = 17'(cfg.c1) * 17'(8'd255 - fac) + 17'(cfg.k0) * 17'(fac);
    s1_mix_nxt = mix_sum[15:0];
    s1_ptc_nxt = 16'(cfg.tint) * 16'(cfg.c0);
  end

  // Stage 2: tint product and the wide normal product.
  logic [15:0] s2_y_r, s2_y_nxt;
  logic [31:0] s2_x_r, s2_x_nxt;

  always_comb begin
    s2_y_nxt = 16'(s1_m_r) * 16'(cfg.tint);
    s2_x_nxt = 32'(s1_ptc_r) * 32'(s1_mix_r);
  end

  // Stage 3: divide the ring product by 255; bias the normal product.
  logic [16:0] y_bias;
  logic [16:0] y_fold;
  logic [7:0]  s3_ring_r, s3_ring_nxt;
  logic [31:0] s3_n_r, s3_n_nxt;

  always_comb begin
    y_bias      = {1'b0, s2_y_r} + 17'd128;
    y_fold      = y_bias + {8'd0, y_bias[16:8]};
    s3_ring_nxt = y_fold[15:8];
    s3_n_nxt    = s2_x_r + tcc_pkg::NORM_HALF;
  end

  // Stage 4: first quotient estimate from the top byte, partial remainder.
  logic [31:0] q0_prod;
  logic [31:0] rem0;
  logic [7:0]  s4_q0_r, s4_q0_nxt;
  logic [25:0] s4_r0_r, s4_r0_nxt;
  logic [7:0]  s4_ring_r;

  always_comb begin
    s4_q0_nxt = s3_n_r[31:24];
    q0_prod   = 32'(s4_q0_nxt) * 32'(tcc_pkg::NORM_DIV);
    rem0      = s3_n_r - q0_prod;
    s4_r0_nxt = rem0[25:0];
  end

  // Stage 5: second estimate, final compare and the mode select.
  logic [1:0]  q1;
  logic [25:0] rem1;
  logic        carry;
  logic [8:0]  quot;
  logic [7:0]  s5_res_r, s5_res_nxt;

  always_comb begin
    q1    = s4_r0_r[25:24];
    rem1  = s4_r0_r - 26'(q1) * 26'(tcc_pkg::NORM_DIV);
    carry = (rem1 >= 26'(tcc_pkg::NORM_DIV));
    quot  = {1'b0, s4_q0_r} + {7'd0, q1} + {8'd0, carry};
    s5_res_nxt = cfg.ring ? s4_ring_r : quot[7:0];
  end

  always_ff @(posedge clk) begin
    s1_m_r    <= s1_m_nxt;
    s1_mix_r  <= s1_mix_nxt;
    s1_ptc_r  <= s1_ptc_nxt;
    s2_y_r    <= s2_y_nxt;
    s2_x_r    <= s2_x_nxt;
    s3_ring_r <= s3_ring_nxt;
    s3_n_r    <= s3_n_nxt;
    s4_q0_r   <= s4_q0_nxt;
    s4_r0_r   <= s4_r0_nxt;
    s4_ring_r <= s3_ring_r;
    s5_res_r  <= s5_res_nxt;
  end

  assign res = s5_res_r;

endmodule

@@ hdl/tcc_checker.sv @@
// ----------------------------------------------------------------------------
// tcc_checker
// Port-level checks of the texel color combiner, bound to the top level.
// ----------------------------------------------------------------------------
`include "texel_color_combiner_assert.svh"

module tcc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_valid,
  input logic                            cfg_valid,
  input logic                            cfg_ready
);

  // When rst_n was already high at the last sampled edge, busy must be low.
  `TCC_ASSERT_NOW(busy_drops, clk, rst_n, $past(rst_n), !busy)

  // Every accepted texel produces a strobe after the pipeline depth.
  `TCC_ASSERT_LATER(beat_to_strobe, clk, rst_n, start && !busy, tcc_pkg::NUM_STAGES, out_valid)

  // No strobe without a texel taken the pipeline depth earlier.
  `TCC_ASSERT_NOW(strobe_has_beat, clk, rst_n, out_valid, $past(start && !busy, tcc_pkg::NUM_STAGES))

  // Configuration writes are never held off.
  `TCC_ASSERT_NOW(cfg_never_held, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind texel_color_combiner tcc_checker u_tcc_checker (.*);
